[src/fpba_pkg.sv]
package fpba_pkg;

  localparam int DEF_MAX_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  // strategy codes; the fourth code falls back to first fit
  localparam logic [1:0] STRAT_FIRST = 2'd0;
  localparam logic [1:0] STRAT_BEST  = 2'd1;
  localparam logic [1:0] STRAT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_STRATEGY      = 1'd0;
  localparam logic [0:0] REG_BLOCKS_IN_USE = 1'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  block_index;
    logic [15:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        allocated;
    logic [3:0]  block_number;
    logic [15:0] space_left;
  } out_item_t;

  typedef struct packed {
    logic fits;    // candidate holds at least the request
    logic better;  // candidate beats the current pick under the strategy
  } cmp_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RESTORE,
    S_SCAN,
    S_SUB,
    S_DONE
  } state_t;

endpackage

[src/fpba_ram.sv]
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic [AW-1:0]          raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/fpba_cmp_unit.sv]
module fpba_cmp_unit import fpba_pkg::*; #(
  parameter int SIZE_BITS = DEF_SIZE_BITS
) (
  input  logic [SIZE_BITS-1:0] a_val,
  input  logic [SIZE_BITS-1:0] b_val,
  input  logic [SIZE_BITS-1:0] c_val,
  input  logic [1:0]           strategy,
  output cmp_flags_t           flags,
  output logic [SIZE_BITS-1:0] diff
);

  always_comb begin
    flags.fits = (a_val >= b_val);
    case (strategy)
      STRAT_BEST:  flags.better = (a_val < c_val);
      STRAT_WORST: flags.better = (a_val > c_val);
      default:     flags.better = 1'b0;
    endcase
    diff = a_val - b_val;
  end

endmodule

[src/fit_policy_block_allocator_core.sv]
// Block table allocator with first, best and worst fit.
//
// Input channel (in_valid/in_ready/in_data) takes one transaction per
// operation: allocate a size, load one block's size, or restore every block's
// free size from its loaded size. Every input transaction yields exactly one
// result transaction on out_valid/out_ready/out_data; only an allocate can
// report allocated = 1. The user must set strategy and search range on the
// cfg_ write port only while the block is idle; the block does not enforce this.
//
// Flow: one transaction at a time; in_ready is high only when idle.
//   allocate : S_SCAN reads the searched blocks (limit = searched blocks)
//              through the single free-size RAM read port, feeding the
//              shared compare unit one block a cycle; S_SUB subtracts.
//   restore  : S_RESTORE covers all MAX_BLOCKS, one block copied per cycle.
//   load : S_LOAD, then S_DONE; unused code : S_DONE; then back to S_IDLE.
// A finished result sits in the output register until taken; a new input may
// be accepted meanwhile, and its result waits in S_DONE while out_ready is low.
// Reset (rst_n low, synchronous) clears the strategy and search range and the
// per-block valid bits, so every block reads as size zero; no clearing pass.
module fit_policy_block_allocator_core import fpba_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // control state
  state_t              state_r, state_nxt;
  logic [1:0]          strategy_r;
  logic [4:0]          blocks_in_use_r;
  logic [MAX_BLOCKS-1:0] vld_r, vld_nxt;
  logic                pend_r, pend_nxt;
  logic                found_r, found_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload / datapath
  logic [3:0]          idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] req_r, req_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       limit_r, limit_nxt;
  logic [IW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [IW-1:0]       pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  out_item_t           res_r, res_nxt;
  out_item_t           out_data_r, out_data_nxt;

  // RAM ports
  logic                free_we;
  logic [IW-1:0]       free_waddr;
  logic [SIZE_BITS-1:0] free_wdata;
  logic [SIZE_BITS-1:0] free_rdata;
  logic                load_we;
  logic [IW-1:0]       load_addr;
  logic [SIZE_BITS-1:0] load_rdata;

  // shared compare/subtract unit
  logic [SIZE_BITS-1:0] scan_f;
  logic [SIZE_BITS-1:0] cmp_a;
  logic [SIZE_BITS-1:0] cmp_diff;
  cmp_flags_t          cmp_flags;

  logic                idx_in_range;
  logic [CW-1:0]       limit_in;

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (cnt_r[IW-1:0]),
    .rdata (free_rdata)
  );

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_load_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (req_r),
    .raddr (cnt_r[IW-1:0]),
    .rdata (load_rdata)
  );

  // never-loaded blocks read as zero
  assign scan_f = vld_r[pend_idx_r] ? free_rdata : '0;
  // scan compares the fetched block; the final step subtracts from the pick
  assign cmp_a  = (state_r == S_SUB) ? best_r : scan_f;

  fpba_cmp_unit #(
    .SIZE_BITS (SIZE_BITS)
  ) u_cmp (
    .a_val    (cmp_a),
    .b_val    (req_r),
    .c_val    (best_r),
    .strategy (strategy_r),
    .flags    (cmp_flags),
    .diff     (cmp_diff)
  );

  assign idx_in_range = (32'(idx_r) < MAX_BLOCKS);
  assign load_addr    = IW'(idx_r);
  // search range saturates at the table size
  assign limit_in     = (32'(blocks_in_use_r) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                            : CW'(blocks_in_use_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    vld_nxt       = vld_r;
    pend_nxt      = pend_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    limit_nxt     = limit_r;
    pend_idx_nxt  = pend_idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    in_ready      = 1'b0;
    free_we       = 1'b0;
    free_waddr    = pick_r;
    free_wdata    = cmp_diff;
    load_we       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          idx_nxt   = in_data.block_index;
          req_nxt   = SIZE_BITS'(in_data.size_value);
          cnt_nxt   = '0;
          limit_nxt = limit_in;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          pick_nxt  = '0;
          best_nxt  = '0;
          res_nxt   = '0;
          case (in_data.operation)
            OP_ALLOC:   state_nxt = S_SCAN;
            OP_LOAD:    state_nxt = S_LOAD;
            OP_RESTORE: state_nxt = S_RESTORE;
            default:    state_nxt = S_DONE;
          endcase
        end
      end

      S_LOAD: begin
        if (idx_in_range) begin
          free_we            = 1'b1;
          free_waddr         = load_addr;
          free_wdata         = req_r;
          load_we            = 1'b1;
          vld_nxt[load_addr] = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_RESTORE: begin
        // read loaded[cnt], write free[cnt-1] from last cycle's read
        if (pend_r) begin
          free_we    = 1'b1;
          free_waddr = pend_idx_r;
          free_wdata = load_rdata;
        end
        if (cnt_r < CW'(MAX_BLOCKS)) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_DONE;
          end
        end
      end

      S_SCAN: begin
        // evaluate the block fetched last cycle; lower index wins ties
        if (pend_r && cmp_flags.fits && (!found_r || cmp_flags.better)) begin
          found_nxt = 1'b1;
          pick_nxt  = pend_idx_r;
          best_nxt  = scan_f;
        end
        if (cnt_r < limit_r) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt      = cnt_r + CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_SUB;
          end
        end
      end

      S_SUB: begin
        if (found_r) begin
          free_we              = 1'b1;
          res_nxt.allocated    = 1'b1;
          res_nxt.block_number = 4'(pick_r);
          res_nxt.space_left   = 16'(cmp_diff);
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      strategy_r      <= STRAT_FIRST;
      blocks_in_use_r <= '0;
      vld_r           <= '0;
      pend_r          <= 1'b0;
      found_r         <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STRATEGY:      strategy_r      <= cfg_wdata[1:0];
          REG_BLOCKS_IN_USE: blocks_in_use_r <= cfg_wdata;
          default:           ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    cnt_r      <= cnt_nxt;
    limit_r    <= limit_nxt;
    pend_idx_r <= pend_idx_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[bench/fit_policy_block_allocator_core_tb.sv]
module fit_policy_block_allocator_core_tb;
  import fpba_pkg::*;

  // table geometry of the block under test
  localparam int MAX_BLOCKS = DEF_MAX_BLOCKS;

  // codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED      = 2'd3;  // operation that does nothing
  localparam logic [1:0] STRAT_FALLBACK = 2'd3;  // decodes as first fit

  // run limits
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 250;  // long receiver hold-off
  localparam int TAIL_CYCLES  = 40;   // above the slowest restore/allocate latency
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 85;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic       cfg_we    = 1'b0;
  logic [0:0] cfg_index = REG_STRATEGY;
  logic [4:0] cfg_wdata = '0;

  // mirror of the block's table and registers
  logic [15:0] free_left  [MAX_BLOCKS];
  logic [15:0] loaded_len [MAX_BLOCKS];
  logic [1:0]  fit_mode;
  logic [4:0]  search_span;

  // expected result transactions, oldest first
  out_item_t grant_queue[$];

  int fail_count  = 0;
  int cycle_count = 0;

  // traffic shaping: quiet turns off random idling on both sides,
  // a change of hold_req starts a long receiver hold-off
  logic quiet     = 1'b0;
  int   hold_req  = 0;
  int   hold_seen = 0;
  int   hold_left = 0;

  fit_policy_block_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL fit_policy_block_allocator_core");
    $finish;
  end

  // Predict one transaction against the mirrored table. Search covers
  // blocks 0 .. span-1 with span clipped to the table size; ties keep the
  // lower index because only a strictly better block replaces the pick.
  // First fit and the fallback code never replace the first fitting block.
  function automatic out_item_t place_request(in_item_t it);
    out_item_t res;
    int span;
    int pick;
    logic [15:0] req;
    res = '0;
    req = it.size_value;
    case (it.operation)
      OP_ALLOC: begin
        span = (search_span > MAX_BLOCKS) ? MAX_BLOCKS : int'(search_span);
        pick = -1;
        for (int j = 0; j < span; j++) begin
          if (free_left[j] >= req) begin
            if (pick < 0) begin
              pick = j;
            end else if (fit_mode == STRAT_BEST && free_left[j] < free_left[pick]) begin
              pick = j;
            end else if (fit_mode == STRAT_WORST && free_left[j] > free_left[pick]) begin
              pick = j;
            end
          end
        end
        if (pick >= 0) begin
          free_left[pick]  = free_left[pick] - req;
          res.allocated    = 1'b1;
          res.block_number = 4'(pick);
          res.space_left   = free_left[pick];
        end
      end
      OP_LOAD: begin
        free_left[it.block_index]  = req;
        loaded_len[it.block_index] = req;
      end
      OP_RESTORE: begin
        for (int j = 0; j < MAX_BLOCKS; j++) begin
          free_left[j] = loaded_len[j];
        end
      end
      default: begin
        // unused code: no state change, empty result
      end
    endcase
    return res;
  endfunction

  // Offer one input transaction and hold it until accepted. The expected
  // result is computed at the accepting edge. Valid stays high afterwards so
  // back-to-back transactions need no extra edge.
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                           input logic [15:0] size);
    in_item_t it;
    it = '{operation: op, block_index: idx, size_value: size};
    if (!quiet && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    grant_queue.push_back(place_request(it));
  endtask

  // Sender pause: drop valid and wait for every outstanding result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (grant_queue.size() != 0);
  endtask

  // Register write; only called with nothing in flight. The trailing edge
  // keeps back-to-back writes from touching cfg_we twice in one step.
  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_STRATEGY) begin
      fit_mode = val[1:0];
    end else begin
      search_span = val;
    end
    @(posedge clk);
  endtask

  // Receiver: random stalls, a long hold-off on request, or always ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 32);
    end
  end

  // Result checker: every accepted result transaction against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grant_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = grant_queue.pop_front();
        if (out_data.allocated !== want.allocated) begin
          $display("%0t: allocated mismatch, expected %0d actual %0d",
                   $time, want.allocated, out_data.allocated);
          fail_count++;
        end
        if (out_data.block_number !== want.block_number) begin
          $display("%0t: block_number mismatch, expected %0d actual %0d",
                   $time, want.block_number, out_data.block_number);
          fail_count++;
        end
        if (out_data.space_left !== want.space_left) begin
          $display("%0t: space_left mismatch, expected %0d actual %0d",
                   $time, want.space_left, out_data.space_left);
          fail_count++;
        end
      end
    end
  end

  // Reset config (no blocks searched): nothing can be allocated, and every
  // non-allocate code still returns an empty result.
  task automatic test_empty_table();
    send_item(OP_ALLOC, 4'd0, 16'd0);
    send_item(OP_LOAD, 4'd15, 16'hFFFF);
    send_item(OP_RESTORE, 4'd7, 16'h1234);
    send_item(OP_UNUSED, 4'd9, 16'hFFFF);
    send_item(OP_ALLOC, 4'd3, 16'hFFFF);
    wait_drained();
  endtask

  // Same table under each strategy code: placement, ties, zero request.
  task automatic test_fit_strategies();
    logic [1:0] modes [4];
    modes = '{STRAT_FIRST, STRAT_BEST, STRAT_WORST, STRAT_FALLBACK};
    write_reg(REG_BLOCKS_IN_USE, 5'd4);
    // blocks 1 and 3 tie for best fit
    send_item(OP_LOAD, 4'd0, 16'd100);
    send_item(OP_LOAD, 4'd1, 16'd50);
    send_item(OP_LOAD, 4'd2, 16'd200);
    send_item(OP_LOAD, 4'd3, 16'd50);
    for (int m = 0; m < 4; m++) begin
      wait_drained();
      write_reg(REG_STRATEGY, {3'b000, modes[m]});
      send_item(OP_RESTORE, 4'd0, 16'd0);
      send_item(OP_ALLOC, 4'd0, 16'd40);
      send_item(OP_ALLOC, 4'd0, 16'd0);
    end
    wait_drained();
  endtask

  // Search range above the table size clips; full-size request empties a block.
  task automatic test_search_range();
    write_reg(REG_BLOCKS_IN_USE, 5'd31);
    write_reg(REG_STRATEGY, {3'b000, STRAT_WORST});
    send_item(OP_LOAD, 4'd15, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'hFFFF);
    send_item(OP_ALLOC, 4'd0, 16'd1);
    wait_drained();
    write_reg(REG_BLOCKS_IN_USE, 5'd16);
    send_item(OP_ALLOC, 4'd0, 16'd0);
    wait_drained();
    write_reg(REG_BLOCKS_IN_USE, 5'd0);
    send_item(OP_ALLOC, 4'd0, 16'd0);
    wait_drained();
  endtask

  // One random transaction: mostly allocates sized to fit the loaded blocks,
  // with loads, restores, the unused code and full-range sizes mixed in.
  task automatic send_random();
    int sel;
    int pct;
    logic [1:0]  op;
    logic [15:0] size;
    sel = $urandom_range(99);
    pct = $urandom_range(99);
    if (sel < 55) begin
      op = OP_ALLOC;
    end else if (sel < 85) begin
      op = OP_LOAD;
    end else if (sel < 93) begin
      op = OP_RESTORE;
    end else begin
      op = OP_UNUSED;
    end
    if (pct < 10) begin
      size = 16'($urandom);
    end else if (pct < 15) begin
      size = 16'd0;
    end else if (pct < 20) begin
      size = 16'hFFFF;
    end else if (op == OP_LOAD) begin
      size = 16'($urandom_range(0, 4095));
    end else begin
      size = 16'($urandom_range(0, 1023));
    end
    send_item(op, 4'($urandom_range(0, 15)), size);
  endtask

  // Receiver holds off while the sender keeps offering, so the block's
  // output and pipeline fill and in_ready drops; then the sender pauses.
  task automatic test_backpressure();
    write_reg(REG_BLOCKS_IN_USE, 5'd16);
    write_reg(REG_STRATEGY, {3'b000, STRAT_BEST});
    hold_req <= hold_req + 1;
    repeat (24) send_random();
    wait_drained();
  endtask

  // Random phases across strategies and search ranges, extremes first.
  task automatic test_random_phases();
    logic [4:0] spans [6];
    spans = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17, 5'd15};
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      write_reg(REG_STRATEGY, {3'b000, 2'(p % 4)});
      write_reg(REG_BLOCKS_IN_USE, (p < 6) ? spans[p] : 5'($urandom_range(0, 31)));
      // one phase runs without any idling on either side
      quiet <= (p == 7);
      send_item(OP_RESTORE, 4'($urandom_range(0, 15)), 16'($urandom));
      repeat (PHASE_ITEMS) send_random();
    end
    wait_drained();
    quiet <= 1'b0;
  endtask

  initial begin
    fit_mode    = STRAT_FIRST;
    search_span = '0;
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      free_left[j]  = '0;
      loaded_len[j] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_fit_strategies();
    test_search_range();
    test_backpressure();
    test_random_phases();

    // catch any stray result after the last expected one
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && grant_queue.size() == 0) begin
      $display("PASS fit_policy_block_allocator_core");
    end else begin
      $display("FAIL fit_policy_block_allocator_core");
    end
    $finish;
  end

endmodule

[files.f]
src/fpba_pkg.sv
src/fpba_ram.sv
src/fpba_cmp_unit.sv
src/fit_policy_block_allocator_core.sv
bench/fit_policy_block_allocator_core_tb.sv
